### rtl/core/assert_macros.svh
// Assertion macros shared by the integrator RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/core/fsei_pkg.sv
// Package for the force-sum Euler integrator: command codes and defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fsei_pkg;
    localparam int DEF_SUB_STEPS     = 1;
    localparam int DEF_FRACTION_BITS = 16;
    localparam logic [31:0] TIME_STEP_RESET = 32'd1092;

    localparam logic [1:0] CMD_BEGIN     = 2'd0;
    localparam logic [1:0] CMD_FORCE     = 2'd1;
    localparam logic [1:0] CMD_INTEGRATE = 2'd2;

    // handshake of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;
endpackage
`default_nettype wire

### rtl/core/fsei_if.sv
// Request channels of the integrator: input items and result items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface fsei_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        body_mass;
    logic               scale_by_speed;
    logic               skip_mass_divide;
    modport source (output valid, cmd, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                    body_mass, scale_by_speed, skip_mass_divide, input ready);
    modport sink   (input valid, cmd, vec_x, vec_y, vec_z, pos_x, pos_y, pos_z,
                    body_mass, scale_by_speed, skip_mass_divide, output ready);
endinterface

interface fsei_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    modport source (output valid, new_vel_x, new_vel_y, new_vel_z,
                    new_pos_x, new_pos_y, new_pos_z, input ready);
    modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z,
                    new_pos_x, new_pos_y, new_pos_z, output ready);
endinterface
`default_nettype wire

### rtl/core/fsei_mul.sv
// Shared registered 34x34 signed multiplier with fixed-point floor shift
// and 32-bit saturation. Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none
module fsei_mul #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic signed [33:0] a,
    input  wire logic signed [33:0] b,
    output logic signed [67:0]      prod,
    output logic signed [31:0]      prod_fix
);
    logic signed [67:0] prod_reg;
    logic signed [67:0] shifted;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // floor shift, then clamp to signed 32 bits
    always_comb
    begin
        shifted = prod_reg >>> FRACTION_BITS;
        if (shifted[67:31] == '0 || shifted[67:31] == '1)
            prod_fix = shifted[31:0];
        else if (shifted[67])
            prod_fix = 32'sh8000_0000;
        else
            prod_fix = 32'sh7FFF_FFFF;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### rtl/core/fsei_div.sv
// Restoring divider, one quotient bit per cycle, DW-bit dividend by a
// 32-bit divisor. Uses fsei_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none
module fsei_div
    import fsei_pkg::*;
#(
    parameter int DW = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [31:0]   divisor,
    output unit_status_t       status,
    output logic [DW-1:0]      quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [31:0]   rem_reg;
    logic [DW-1:0] quo_reg;
    logic [31:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [32:0]   shifted;
    logic [32:0]   diff;
    logic          ge;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = !diff[32];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
endmodule
`default_nettype wire

### rtl/core/fsei_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per
// cycle. Uses fsei_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none
module fsei_sqrt
    import fsei_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output unit_status_t     status,
    output logic [31:0]      root
);
    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] shifted;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    // trial subtraction of 4*root+1
    always_comb
    begin
        shifted = {rem_reg, x_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = !diff[35];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : shifted[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;
endmodule
`default_nettype wire

### rtl/core/force_sum_euler_integrator.sv
// Force-sum semi-implicit Euler integrator, one body per item sequence.
//
// Channels: in_ch takes requests (begin body, add force, integrate); out_ch
// gives one result per integrate request: new velocity and position, Q16.16.
// cfg_we/cfg_wdata write time_step; write only while the block is idle.
// One request at a time: in_ch.ready is high only between requests.
// Steps (divider loop over DW = 32 + FRACTION_BITS bits, 1 bit/cycle):
//   begin: loads the body from the request.
//   force: [scale, speed unknown] three squares and the root loop; then per
//     axis a load, [scale] a multiply by speed, [divide] a divide by mass, an add.
//   integrate: the sub-step time (reciprocal multiply), then per sub-step
//     and axis a velocity and a position update through the shared
//     multiplier, then the output register is loaded.
// The output register parts the two sides: later begin and force requests
// run while a result waits; an integrate holds until out_ch.ready frees it.
// Reset clears all body state, empties the output and sets time_step to
// 1092. Depends on fsei_pkg, fsei_if, fsei_mul, fsei_div, fsei_sqrt and
// assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module force_sum_euler_integrator
    import fsei_pkg::*;
#(
    parameter int SUB_STEPS     = DEF_SUB_STEPS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [31:0] cfg_wdata,
    fsei_in_if.sink    in_ch,
    fsei_out_if.source out_ch
);
    localparam int DW    = 32 + FRACTION_BITS;
    localparam int SUB_W = $clog2(SUB_STEPS + 1);
    // floor(time_step / SUB_STEPS) as (time_step * DT_RECIP) >> DT_K
    localparam int DT_L  = $clog2(SUB_STEPS);
    localparam int DT_K  = 32 + DT_L;
    localparam logic [33:0] DT_RECIP =
        34'(((64'd1 << DT_K) + 64'(SUB_STEPS) - 64'd1) / 64'(SUB_STEPS));

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SQ_MUL  = 5'd1;
    localparam logic [4:0] ST_SQ_ACC  = 5'd2;
    localparam logic [4:0] ST_SQRT_GO = 5'd3;
    localparam logic [4:0] ST_SQRT_W  = 5'd4;
    localparam logic [4:0] ST_F_LOAD  = 5'd5;
    localparam logic [4:0] ST_F_MUL   = 5'd6;
    localparam logic [4:0] ST_F_MULW  = 5'd7;
    localparam logic [4:0] ST_F_CHK   = 5'd8;
    localparam logic [4:0] ST_F_DIVW  = 5'd9;
    localparam logic [4:0] ST_F_ADD   = 5'd10;
    localparam logic [4:0] ST_DT_DIV  = 5'd11;
    localparam logic [4:0] ST_DT_W    = 5'd12;
    localparam logic [4:0] ST_I_MV    = 5'd13;
    localparam logic [4:0] ST_I_V     = 5'd14;
    localparam logic [4:0] ST_I_MP    = 5'd15;
    localparam logic [4:0] ST_I_P     = 5'd16;
    localparam logic [4:0] ST_EMIT    = 5'd17;

    logic [4:0]         state_reg;
    logic [1:0]         idx_reg;
    logic [SUB_W-1:0]   sub_reg;
    logic [31:0]        time_step_reg;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] acc_reg [3];
    logic [31:0]        mass_reg;
    logic [31:0]        speed_reg;
    logic               known_reg;
    logic signed [31:0] f_in_reg [3];
    logic               scale_reg;
    logic               skip_reg;
    logic signed [31:0] f_cur_reg;
    logic [63:0]        sum_reg;
    logic [31:0]        dt_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_vel_reg [3];
    logic signed [31:0] out_pos_reg [3];

    logic               accept;
    logic               emit;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod;
    logic signed [31:0] prod_fix;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [31:0]        div_divisor;
    logic [DW-1:0]      quotient;
    logic signed [31:0] quo_fix;
    logic [31:0]        f_mag;
    logic               div_needed;
    logic               sqrt_start;
    logic [31:0]        root;
    unit_status_t       div_status;
    unit_status_t       sqrt_status;

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    assign accept = in_ch.valid && in_ch.ready;
    assign emit   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = {{2{vel_reg[idx_reg][31]}}, vel_reg[idx_reg]};
                mul_b = {{2{vel_reg[idx_reg][31]}}, vel_reg[idx_reg]};
            end
            ST_F_MUL:
            begin
                mul_a = {{2{f_cur_reg[31]}}, f_cur_reg};
                mul_b = {2'b00, speed_reg};
            end
            ST_DT_DIV:
            begin
                mul_a = {2'b00, time_step_reg};
                mul_b = DT_RECIP;
            end
            ST_I_MV:
            begin
                mul_a = {{2{acc_reg[idx_reg][31]}}, acc_reg[idx_reg]};
                mul_b = {2'b00, dt_reg};
            end
            default:
            begin
                mul_a = {{2{vel_reg[idx_reg][31]}}, vel_reg[idx_reg]};
                mul_b = {2'b00, dt_reg};
            end
        endcase
    end

    // divider operands: force magnitude over mass; root start
    always_comb
    begin
        f_mag        = f_cur_reg[31] ? 32'(-f_cur_reg) : 32'(f_cur_reg);
        div_needed   = !skip_reg && (mass_reg != '0);
        div_start    = (state_reg == ST_F_CHK) && div_needed;
        div_dividend = {f_mag, {FRACTION_BITS{1'b0}}};
        div_divisor  = mass_reg;
        sqrt_start   = (state_reg == ST_SQRT_GO);
    end

    // signed, saturated quotient
    always_comb
    begin
        if (f_cur_reg[31])
        begin
            if (quotient > DW'(33'h0_8000_0000))
                quo_fix = 32'sh8000_0000;
            else
                quo_fix = 32'(-quotient[31:0]);
        end
        else
        begin
            if (quotient > DW'(32'h7FFF_FFFF))
                quo_fix = 32'sh7FFF_FFFF;
            else
                quo_fix = quotient[31:0];
        end
    end

    fsei_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod     (prod),
        .prod_fix (prod_fix)
    );

    fsei_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (quotient)
    );

    fsei_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .status   (sqrt_status),
        .root     (root)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RESET;
        else if (cfg_we)
            time_step_reg <= cfg_wdata;
    end

    // sequencer and body state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            sub_reg       <= '0;
            mass_reg      <= '0;
            speed_reg     <= '0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= '0;
                        sub_reg <= '0;
                        sum_reg <= '0;
                        case (in_ch.cmd)
                            CMD_BEGIN:
                            begin
                                vel_reg[0] <= in_ch.vec_x;
                                vel_reg[1] <= in_ch.vec_y;
                                vel_reg[2] <= in_ch.vec_z;
                                pos_reg[0] <= in_ch.pos_x;
                                pos_reg[1] <= in_ch.pos_y;
                                pos_reg[2] <= in_ch.pos_z;
                                for (int i = 0; i < 3; i++)
                                    acc_reg[i] <= '0;
                                mass_reg  <= in_ch.body_mass;
                                known_reg <= 1'b0;
                            end
                            CMD_FORCE:
                            begin
                                if (in_ch.scale_by_speed && !known_reg)
                                    state_reg <= ST_SQ_MUL;
                                else
                                    state_reg <= ST_F_LOAD;
                            end
                            CMD_INTEGRATE:
                                state_reg <= ST_DT_DIV;
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SQ_MUL:
                    state_reg <= ST_SQ_ACC;
                ST_SQ_ACC:
                begin
                    sum_reg <= sum_reg + prod[63:0];
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SQRT_GO;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT_GO:
                    state_reg <= ST_SQRT_W;
                ST_SQRT_W:
                begin
                    if (sqrt_status.done)
                    begin
                        speed_reg <= root;
                        known_reg <= 1'b1;
                        state_reg <= ST_F_LOAD;
                    end
                end
                ST_F_LOAD:
                begin
                    f_cur_reg <= f_in_reg[idx_reg];
                    state_reg <= scale_reg ? ST_F_MUL : ST_F_CHK;
                end
                ST_F_MUL:
                    state_reg <= ST_F_MULW;
                ST_F_MULW:
                begin
                    f_cur_reg <= prod_fix;
                    state_reg <= ST_F_CHK;
                end
                ST_F_CHK:
                    state_reg <= div_needed ? ST_F_DIVW : ST_F_ADD;
                ST_F_DIVW:
                begin
                    if (div_status.done)
                    begin
                        f_cur_reg <= quo_fix;
                        state_reg <= ST_F_ADD;
                    end
                end
                ST_F_ADD:
                begin
                    acc_reg[idx_reg] <= add_sat(acc_reg[idx_reg], f_cur_reg);
                    if (idx_reg == 2'd2)
                        state_reg <= ST_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_F_LOAD;
                    end
                end
                ST_DT_DIV:
                    state_reg <= ST_DT_W;
                ST_DT_W:
                begin
                    dt_reg    <= prod[DT_K+31:DT_K];
                    state_reg <= ST_I_MV;
                end
                ST_I_MV:
                    state_reg <= ST_I_V;
                ST_I_V:
                begin
                    vel_reg[idx_reg] <= add_sat(vel_reg[idx_reg], prod_fix);
                    state_reg        <= ST_I_MP;
                end
                ST_I_MP:
                    state_reg <= ST_I_P;
                ST_I_P:
                begin
                    pos_reg[idx_reg] <= add_sat(pos_reg[idx_reg], prod_fix);
                    if (idx_reg == 2'd2)
                    begin
                        idx_reg <= '0;
                        if (sub_reg == SUB_W'(SUB_STEPS - 1))
                            state_reg <= ST_EMIT;
                        else
                        begin
                            sub_reg   <= sub_reg + 1'b1;
                            state_reg <= ST_I_MV;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_I_MV;
                    end
                end
                ST_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                            acc_reg[i] <= '0;
                        known_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // request payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_in_reg[0] <= in_ch.vec_x;
            f_in_reg[1] <= in_ch.vec_y;
            f_in_reg[2] <= in_ch.vec_z;
            scale_reg   <= in_ch.scale_by_speed;
            skip_reg    <= in_ch.skip_mass_divide;
        end
        if (emit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_vel_reg[i] <= vel_reg[i];
                out_pos_reg[i] <= pos_reg[i];
            end
        end
    end

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.new_vel_x = out_vel_reg[0];
    assign out_ch.new_vel_y = out_vel_reg[1];
    assign out_ch.new_vel_z = out_vel_reg[2];
    assign out_ch.new_pos_x = out_pos_reg[0];
    assign out_ch.new_pos_y = out_pos_reg[1];
    assign out_ch.new_pos_z = out_pos_reg[2];

    // checks
    `ASSERT_IMPLY(a_div_done_state, clk, rst_n, div_status.done,
        state_reg == ST_F_DIVW, "divider done outside its wait")
    `ASSERT_IMPLY(a_sqrt_done_state, clk, rst_n, sqrt_status.done,
        state_reg == ST_SQRT_W, "root done outside its wait")
    `ASSERT_IMPLY(a_idle_units_free, clk, rst_n, in_ch.ready,
        !div_status.busy && !sqrt_status.busy, "ready while a unit is busy")
    `ASSERT_NEXT(a_emit_clears, clk, rst_n, emit,
        out_valid_reg && !known_reg && acc_reg[0] == '0, "emit did not clear state")
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for force_sum_euler_integrator: random body sequences
// with a local fixed-point integrator model. Depends on fsei_pkg and fsei_if.
`timescale 1ns / 1ps
module testbench;
    import fsei_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int FRAC      = DEF_FRACTION_BITS;
    localparam int SETTLE    = 400;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] vec [3];
        logic signed [31:0] pos [3];
        logic [31:0]        mass;
        logic               scale;
        logic               skip;
    } body_req_t;

    typedef struct {
        logic signed [31:0] vel [3];
        logic signed [31:0] pos [3];
    } body_state_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    fsei_in_if  in_ch ();
    fsei_out_if out_ch ();

    force_sum_euler_integrator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // model state
    logic [31:0]        m_time_step;
    logic signed [31:0] m_vel [3];
    logic signed [31:0] m_pos [3];
    logic [31:0]        m_mass;
    logic signed [31:0] m_accel [3];
    logic [31:0]        m_speed;
    logic               m_speed_known;

    body_req_t   pending_reqs [$];
    body_state_t expected_states [$];
    body_req_t   cur_req;
    int          in_gap;
    int          out_gap;
    int          fail_count;
    int          mismatch_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // product shifted with floor, then saturated
    function automatic logic signed [31:0] mul_fix(logic signed [31:0] s, logic [31:0] u);
        longint p;
        p = longint'(s) * longint'(u);
        return sat32(p >>> FRAC);
    endfunction

    // truncating divide by mass
    function automatic logic signed [31:0] div_fix(logic signed [31:0] s, logic [31:0] m);
        longint mag;
        longint q;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        q = (mag << FRAC) / longint'(m);
        return sat32((s < 0) ? -q : q);
    endfunction

    function automatic logic [31:0] speed_of(logic signed [31:0] v [3]);
        bit [63:0] x;
        bit [63:0] res;
        bit [63:0] b;
        longint    t;
        x = 0;
        for (int i = 0; i < 3; i++)
        begin
            t = longint'(v[i]);
            x += 64'(t * t);
        end
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return (res > 64'hffffffff) ? 32'hffffffff : res[31:0];
    endfunction

    // advance the model by one accepted request
    task automatic integrate_body(body_req_t r);
        logic signed [31:0] f;
        logic [31:0]        dt;
        body_state_t        st;
        case (r.cmd)
            CMD_BEGIN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_vel[i]   = r.vec[i];
                    m_pos[i]   = r.pos[i];
                    m_accel[i] = 0;
                end
                m_mass = r.mass;
                m_speed_known = 1'b0;
            end
            CMD_FORCE:
            begin
                if (r.scale && !m_speed_known)
                begin
                    m_speed = speed_of(m_vel);
                    m_speed_known = 1'b1;
                end
                for (int i = 0; i < 3; i++)
                begin
                    f = r.vec[i];
                    if (r.scale)
                        f = mul_fix(f, m_speed);
                    if (!r.skip && m_mass != 0)
                        f = div_fix(f, m_mass);
                    m_accel[i] = sat32(longint'(m_accel[i]) + longint'(f));
                end
            end
            CMD_INTEGRATE:
            begin
                dt = m_time_step / DEF_SUB_STEPS;
                for (int s = 0; s < DEF_SUB_STEPS; s++)
                    for (int i = 0; i < 3; i++)
                    begin
                        m_vel[i] = sat32(longint'(m_vel[i]) + longint'(mul_fix(m_accel[i], dt)));
                        m_pos[i] = sat32(longint'(m_pos[i]) + longint'(mul_fix(m_vel[i], dt)));
                    end
                for (int i = 0; i < 3; i++)
                begin
                    st.vel[i] = m_vel[i];
                    st.pos[i] = m_pos[i];
                    m_accel[i] = 0;
                end
                m_speed_known = 1'b0;
                expected_states.push_back(st);
            end
            default:
            begin
            end
        endcase
    endtask

    // half no gap, most others short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4: return $urandom();
            default: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
        endcase
    endfunction

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'hffffffff;
            2: return $urandom();
            default: return $urandom_range(32'h00004000, 32'h00400000);
        endcase
    endfunction

    function automatic body_req_t make_req(logic [1:0] c);
        body_req_t r;
        r.cmd = c;
        for (int i = 0; i < 3; i++)
        begin
            r.vec[i] = pick_value();
            r.pos[i] = pick_value();
        end
        r.mass  = pick_mass();
        r.scale = $urandom_range(0, 1);
        r.skip  = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    // one body: begin, a few forces, integrate; some broken or noisy ones
    task automatic queue_body();
        int n;
        if ($urandom_range(0, 9) != 0)
            pending_reqs.push_back(make_req(CMD_BEGIN));
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(make_req(CMD_FORCE));
        if ($urandom_range(0, 19) == 0)
            pending_reqs.push_back(make_req(CMD_UNUSED));
        if ($urandom_range(0, 4) != 0)
            pending_reqs.push_back(make_req(CMD_INTEGRATE));
    endtask

    task automatic queue_random(int count);
        int target;
        target = pending_reqs.size() + count;
        while (pending_reqs.size() < target)
            queue_body();
    endtask

    // wait until all requests are accepted and all results are back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_ch.valid || expected_states.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_time_step(logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        m_time_step = v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_directed();
        body_req_t r;
        // force and integrate on the reset state
        pending_reqs.push_back(make_req(CMD_FORCE));
        pending_reqs.push_back(make_req(CMD_INTEGRATE));
        // extremes, zero mass, scale and skip
        r = make_req(CMD_BEGIN);
        r.vec = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
        r.pos = '{32'sh80000000, 32'sh7fffffff, 0};
        r.mass = 0;
        pending_reqs.push_back(r);
        r = make_req(CMD_FORCE);
        r.vec = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000};
        r.scale = 1'b1;
        r.skip = 1'b0;
        pending_reqs.push_back(r);
        r.scale = 1'b0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_UNUSED));
        pending_reqs.push_back(make_req(CMD_INTEGRATE));
        r = make_req(CMD_BEGIN);
        r.mass = 32'hffffffff;
        pending_reqs.push_back(r);
        r = make_req(CMD_FORCE);
        r.vec = '{32'sh80000000, 32'sh7fffffff, -32'sh1};
        r.skip = 1'b1;
        r.scale = 1'b1;
        pending_reqs.push_back(r);
        r.skip = 1'b0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_INTEGRATE));
        // body stays loaded over a second frame
        r = make_req(CMD_FORCE);
        r.scale = 1'b1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_INTEGRATE));
        r = make_req(CMD_BEGIN);
        r.mass = 32'h00000001;
        pending_reqs.push_back(r);
        r = make_req(CMD_FORCE);
        r.skip = 1'b0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(CMD_INTEGRATE));
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                integrate_body(cur_req);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_ch.valid            <= 1'b1;
                    in_ch.cmd              <= cur_req.cmd;
                    in_ch.vec_x            <= cur_req.vec[0];
                    in_ch.vec_y            <= cur_req.vec[1];
                    in_ch.vec_z            <= cur_req.vec[2];
                    in_ch.pos_x            <= cur_req.pos[0];
                    in_ch.pos_y            <= cur_req.pos[1];
                    in_ch.pos_z            <= cur_req.pos[2];
                    in_ch.body_mass        <= cur_req.mass;
                    in_ch.scale_by_speed   <= cur_req.scale;
                    in_ch.skip_mass_divide <= cur_req.skip;
                    in_gap = pick_gap();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_states.size() == 0)
                begin
                    fail_count++;
                    $display("unexpected result at %0t", $realtime);
                end
                else
                begin
                    body_state_t e;
                    logic signed [31:0] got [6];
                    e = expected_states.pop_front();
                    got = '{out_ch.new_vel_x, out_ch.new_vel_y, out_ch.new_vel_z,
                            out_ch.new_pos_x, out_ch.new_pos_y, out_ch.new_pos_z};
                    for (int i = 0; i < 6; i++)
                    begin
                        logic signed [31:0] want;
                        want = (i < 3) ? e.vel[i] : e.pos[i - 3];
                        if (got[i] !== want)
                        begin
                            fail_count++;
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("mismatch field %0d: expected %h got %h",
                                         i, want, got[i]);
                        end
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_gap = pick_gap();
            end
        end
    end

    // stimulus phases
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        mismatch_count = 0;
        m_time_step = TIME_STEP_RESET;
        for (int i = 0; i < 3; i++)
        begin
            m_vel[i] = 0;
            m_pos[i] = 0;
            m_accel[i] = 0;
        end
        m_mass = 0;
        m_speed = 0;
        m_speed_known = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_BEGIN;
        in_ch.vec_x = 0;
        in_ch.vec_y = 0;
        in_ch.vec_z = 0;
        in_ch.pos_x = 0;
        in_ch.pos_y = 0;
        in_ch.pos_z = 0;
        in_ch.body_mass = 0;
        in_ch.scale_by_speed = 1'b0;
        in_ch.skip_mass_divide = 1'b0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        queue_random(200);
        // sender holds off until every result is back
        drain();
        queue_random(200);
        drain();
        write_time_step(32'hffffffff);
        queue_random(300);
        drain();
        write_time_step(32'h00000000);
        queue_random(250);
        drain();
        write_time_step(32'h00010000);
        queue_random(300);
        drain();
        write_time_step($urandom());
        queue_random(250);
        drain();
        write_time_step(TIME_STEP_RESET);
        queue_random(250);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### force_sum_euler_integrator.f
+incdir+rtl/core
rtl/core/fsei_pkg.sv
rtl/core/fsei_if.sv
rtl/core/fsei_mul.sv
rtl/core/fsei_div.sv
rtl/core/fsei_sqrt.sv
rtl/core/force_sum_euler_integrator.sv
dv/testbench.sv
